// ===== rtl/core/lnsc_pkg.sv =====
// Shared types and constants for the letterbox nearest-neighbor scaler.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none
package lnsc_pkg;

    localparam int DIM_W      = 13;
    localparam int COORD_W    = 12;
    localparam int IDX_W      = 16;
    localparam int PIX_W      = 32;
    localparam int ST_W       = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int PROD_W     = 2 * DIM_W;
    localparam int NUM_W      = COORD_W + DIM_W;
    localparam int DIV_STEPS  = DIM_W;
    localparam int QDEPTH     = 4;

    localparam int DEF_FRAME_PIXELS = 65536;
    localparam int DEF_MAX_DIM      = 4096;

    localparam logic [ST_W-1:0] ST_OK         = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_CANVAS = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_FRAME  = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_INDEX  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_W  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_H  = 8'd3;

    localparam logic [PIX_W-1:0] BG_PIXEL = 32'hFF00_0000;

    // what the back end does with an item
    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_BG,
        KIND_NONE
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [ST_W-1:0]    status;
        logic [IDX_W-1:0]   idx;
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] dy;
        logic [COORD_W-1:0] dx;
    } item_t;

    typedef struct packed {
        logic [DIM_W-1:0] fw;
        logic [DIM_W-1:0] fh;
        logic [DIM_W-1:0] tw;
        logic [DIM_W-1:0] th;
    } geom_t;

endpackage
`default_nettype wire

// ===== rtl/core/letterbox_nearest_scaler_core.sv =====
// Letterbox nearest-neighbor scaler top level: front end, item queue, back end.
// Depends on lnsc_pkg, lnsc_front, lnsc_fifo, lnsc_back.
//
// Usage:
//   cfg_*  : register writes (0 canvas width, 1 canvas height, 2 frame width,
//            3 frame height, low 13 bits kept). Each write refits the target
//            rectangle (multiply, 26-step serial divider, finish); s_ready is
//            low meanwhile. The same refit runs after reset.
//   s_*    : cmd 0 writes s_pixel_value at s_pixel_index into the frame store,
//            cmd 1 reads canvas pixel (s_canvas_x, s_canvas_y).
//   m_*    : one result per item, in order: rgba (reads) and status.
// From input accept to m_valid an item passes queue pop with multiply, 13 stages of
// source row/column division, address multiply-add and store read, in that order.
// Throughput is one item per cycle outside a refit; the frame store has one port,
// used by one item a cycle. When m_ready is low the whole back end holds and the
// 4-entry queue takes items until full, then s_ready drops.
// Reset clears control state; store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module letterbox_nearest_scaler_core #(
    parameter int FRAME_PIXELS = lnsc_pkg::DEF_FRAME_PIXELS,
    parameter int MAX_DIM      = lnsc_pkg::DEF_MAX_DIM
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [lnsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lnsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_cmd,
    input  wire logic [lnsc_pkg::IDX_W-1:0]       s_pixel_index,
    input  wire logic [lnsc_pkg::PIX_W-1:0]       s_pixel_value,
    input  wire logic [lnsc_pkg::COORD_W-1:0]     s_canvas_x,
    input  wire logic [lnsc_pkg::COORD_W-1:0]     s_canvas_y,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [lnsc_pkg::PIX_W-1:0]            m_rgba,
    output logic [lnsc_pkg::ST_W-1:0]             m_status
);
    logic            push, q_full, q_valid, q_pop;
    lnsc_pkg::item_t item, q_item;
    lnsc_pkg::geom_t geom;

    assign cfg_ready = 1'b1;

    lnsc_front #(
        .FRAME_PIXELS (FRAME_PIXELS),
        .MAX_DIM      (MAX_DIM)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_pixel_index (s_pixel_index),
        .s_pixel_value (s_pixel_value),
        .s_canvas_x    (s_canvas_x),
        .s_canvas_y    (s_canvas_y),
        .q_full        (q_full),
        .push          (push),
        .item          (item),
        .geom          (geom)
    );

    lnsc_fifo #(
        .DEPTH (lnsc_pkg::QDEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (item),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_item)
    );

    lnsc_back #(
        .FRAME_PIXELS (FRAME_PIXELS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .geom     (geom),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_rgba   (m_rgba),
        .m_status (m_status)
    );
endmodule
`default_nettype wire

// ===== rtl/core/lnsc_front.sv =====
// Front end: configuration registers, target rectangle fit, item classification.
// Depends on lnsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lnsc_front #(
    parameter int FRAME_PIXELS = lnsc_pkg::DEF_FRAME_PIXELS,
    parameter int MAX_DIM      = lnsc_pkg::DEF_MAX_DIM
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [lnsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [lnsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_cmd,
    input  wire logic [lnsc_pkg::IDX_W-1:0]       s_pixel_index,
    input  wire logic [lnsc_pkg::PIX_W-1:0]       s_pixel_value,
    input  wire logic [lnsc_pkg::COORD_W-1:0]     s_canvas_x,
    input  wire logic [lnsc_pkg::COORD_W-1:0]     s_canvas_y,
    input  wire logic                             q_full,
    output logic                                  push,
    output lnsc_pkg::item_t                       item,
    output lnsc_pkg::geom_t                       geom
);
    localparam int DW = lnsc_pkg::DIM_W;
    localparam int CW = lnsc_pkg::COORD_W;
    localparam int PW = lnsc_pkg::PROD_W;

    typedef enum logic [1:0] {G_IDLE, G_MUL, G_DIV, G_FIN} gstate_t;

    gstate_t       state_reg;
    logic [DW-1:0] cw_reg, ch_reg, fw_reg, fh_reg;
    logic [PW-1:0] fwch_reg, cwfh_reg, area_reg;
    logic          wide_reg, cok_reg, fok_reg;
    logic [DW-1:0] rem_reg, q_reg;
    logic [4:0]    cnt_reg;
    logic [DW-1:0] tw_reg, th_reg;
    logic [CW-1:0] ox_reg, oy_reg;

    logic [PW-1:0] fwch_next, cwfh_next, area_next;
    logic          cok_next, fok_next;
    logic [PW-1:0] num;
    logic [DW-1:0] dsor, qq, tw_next, th_next, rem_next;
    logic [DW:0]   ext;
    logic          ge;

    always_comb begin
        fwch_next = PW'(fw_reg) * PW'(ch_reg);
        cwfh_next = PW'(cw_reg) * PW'(fh_reg);
        area_next = PW'(fw_reg) * PW'(fh_reg);
        cok_next  = cw_reg != '0 && ch_reg != '0 &&
                    32'(cw_reg) <= 32'(MAX_DIM) && 32'(ch_reg) <= 32'(MAX_DIM);
        fok_next  = fw_reg != '0 && fh_reg != '0 && 32'(area_next) <= 32'(FRAME_PIXELS);
        // one restoring step of the fit division per cycle
        num       = wide_reg ? cwfh_reg : fwch_reg;
        dsor      = wide_reg ? fw_reg : fh_reg;
        ext       = {rem_reg, num[cnt_reg]};
        ge        = ext >= {1'b0, dsor};
        rem_next  = ge ? DW'(ext - {1'b0, dsor}) : ext[DW-1:0];
        qq        = (q_reg == '0) ? DW'(1) : q_reg;
        tw_next   = wide_reg ? cw_reg : qq;
        th_next   = wide_reg ? qq : ch_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_MUL;
            cw_reg    <= DW'(1);
            ch_reg    <= DW'(1);
            fw_reg    <= DW'(1);
            fh_reg    <= DW'(1);
            cok_reg   <= 1'b0;
            fok_reg   <= 1'b0;
        end else begin
            unique case (state_reg)
                G_IDLE: ;
                G_MUL: begin
                    fwch_reg  <= fwch_next;
                    cwfh_reg  <= cwfh_next;
                    area_reg  <= area_next;
                    wide_reg  <= fwch_next >= cwfh_next;
                    cok_reg   <= cok_next;
                    fok_reg   <= fok_next;
                    rem_reg   <= '0;
                    q_reg     <= '0;
                    cnt_reg   <= 5'(PW - 1);
                    state_reg <= G_DIV;
                end
                G_DIV: begin
                    rem_reg <= rem_next;
                    q_reg   <= {q_reg[DW-2:0], ge};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= G_FIN;
                    end
                end
                G_FIN: begin
                    tw_reg    <= tw_next;
                    th_reg    <= th_next;
                    ox_reg    <= CW'((cw_reg - tw_next) >> 1);
                    oy_reg    <= CW'((ch_reg - th_next) >> 1);
                    state_reg <= G_IDLE;
                end
                default: state_reg <= G_MUL;
            endcase
            if (cfg_valid) begin
                unique case (cfg_index)
                    lnsc_pkg::REG_CANVAS_W: cw_reg <= cfg_data[DW-1:0];
                    lnsc_pkg::REG_CANVAS_H: ch_reg <= cfg_data[DW-1:0];
                    lnsc_pkg::REG_FRAME_W:  fw_reg <= cfg_data[DW-1:0];
                    lnsc_pkg::REG_FRAME_H:  fh_reg <= cfg_data[DW-1:0];
                    default: ;
                endcase
                state_reg <= G_MUL;
            end
        end
    end

    assign s_ready = (state_reg == G_IDLE) && !q_full;
    assign push    = s_valid && s_ready;
    assign geom    = '{fw: fw_reg, fh: fh_reg, tw: tw_reg, th: th_reg};

    logic [CW+1:0] xend, yend;
    logic          out_canvas, out_rect;

    always_comb begin
        xend       = (CW+2)'(ox_reg) + (CW+2)'(tw_reg);
        yend       = (CW+2)'(oy_reg) + (CW+2)'(th_reg);
        out_canvas = {1'b0, s_canvas_x} >= cw_reg || {1'b0, s_canvas_y} >= ch_reg;
        out_rect   = s_canvas_x < ox_reg || (CW+2)'(s_canvas_x) >= xend ||
                     s_canvas_y < oy_reg || (CW+2)'(s_canvas_y) >= yend;
        item.idx    = s_pixel_index;
        item.value  = s_pixel_value;
        item.dx     = s_canvas_x - ox_reg;
        item.dy     = s_canvas_y - oy_reg;
        item.status = lnsc_pkg::ST_OK;
        item.kind   = lnsc_pkg::KIND_NONE;
        if (!s_cmd) begin
            if (!fok_reg) begin
                item.status = lnsc_pkg::ST_BAD_FRAME;
            end else if (PW'(s_pixel_index) >= area_reg ||
                         32'(s_pixel_index) >= 32'(FRAME_PIXELS)) begin
                item.status = lnsc_pkg::ST_BAD_INDEX;
            end else begin
                item.kind = lnsc_pkg::KIND_WRITE;
            end
        end else begin
            if (!cok_reg) begin
                item.status = lnsc_pkg::ST_BAD_CANVAS;
            end else if (!fok_reg) begin
                item.status = lnsc_pkg::ST_BAD_FRAME;
            end else if (out_canvas || out_rect) begin
                item.kind = lnsc_pkg::KIND_BG;
            end else begin
                item.kind = lnsc_pkg::KIND_READ;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/lnsc_fifo.sv =====
// Short item queue between the front and back ends.
// Depends on lnsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lnsc_fifo #(
    parameter int DEPTH = lnsc_pkg::QDEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lnsc_pkg::item_t din,
    output logic                 full,
    input  wire logic            pop,
    output logic                 valid,
    output lnsc_pkg::item_t      dout
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    lnsc_pkg::item_t mem_reg [0:DEPTH-1];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [AW:0]     cnt_reg;

    function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : AW'(p + 1'b1);
    endfunction

    assign full  = cnt_reg == (AW+1)'(DEPTH);
    assign valid = cnt_reg != '0;
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= incr(wp_reg);
            end
            if (pop) begin
                rp_reg <= incr(rp_reg);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/lnsc_back.sv =====
// Back end: source coordinate division pipeline, frame store and result register.
// Depends on lnsc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lnsc_back #(
    parameter int FRAME_PIXELS = lnsc_pkg::DEF_FRAME_PIXELS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          q_valid,
    input  wire lnsc_pkg::item_t               q_item,
    output logic                               q_pop,
    input  wire lnsc_pkg::geom_t               geom,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lnsc_pkg::PIX_W-1:0]         m_rgba,
    output logic [lnsc_pkg::ST_W-1:0]          m_status
);
    localparam int DW = lnsc_pkg::DIM_W;
    localparam int NW = lnsc_pkg::NUM_W;
    localparam int PW = lnsc_pkg::PROD_W;
    localparam int NS = lnsc_pkg::DIV_STEPS;
    localparam int AW = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

    typedef struct packed {
        logic                           vld;
        lnsc_pkg::kind_t                kind;
        logic [lnsc_pkg::ST_W-1:0]      status;
        logic [lnsc_pkg::IDX_W-1:0]     idx;
        logic [lnsc_pkg::PIX_W-1:0]     value;
    } stage_t;

    stage_t pipe_reg [0:NS];
    stage_t a_reg, o_reg;

    logic [DW-1:0] rrem_reg [0:NS], rlow_reg [0:NS], rq_reg [0:NS];
    logic [DW-1:0] crem_reg [0:NS], clow_reg [0:NS], cq_reg [0:NS];
    logic [AW-1:0] addr_reg;
    logic [lnsc_pkg::PIX_W-1:0] rd_reg;
    logic [lnsc_pkg::PIX_W-1:0] mem [0:FRAME_PIXELS-1];

    logic          en;
    logic [NW-1:0] nr, nc;
    logic [DW:0]   rext [0:NS-1], cext [0:NS-1];
    logic          rge [0:NS-1], cge [0:NS-1];
    logic [PW-1:0] lin;

    assign en    = !o_reg.vld || m_ready;
    assign q_pop = en && q_valid;

    always_comb begin
        nr = NW'(q_item.dy) * NW'(geom.fh);
        nc = NW'(q_item.dx) * NW'(geom.fw);
        for (int k = 0; k < NS; k++) begin
            rext[k] = {rrem_reg[k], rlow_reg[k][DW-1]};
            cext[k] = {crem_reg[k], clow_reg[k][DW-1]};
            rge[k]  = rext[k] >= {1'b0, geom.th};
            cge[k]  = cext[k] >= {1'b0, geom.tw};
        end
        lin = PW'(rq_reg[NS]) * PW'(geom.fw) + PW'(cq_reg[NS]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NS; k++) begin
                pipe_reg[k].vld <= 1'b0;
            end
            a_reg.vld <= 1'b0;
            o_reg.vld <= 1'b0;
        end else if (en) begin
            pipe_reg[0] <= '{vld: q_valid, kind: q_item.kind, status: q_item.status,
                             idx: q_item.idx, value: q_item.value};
            for (int k = 1; k <= NS; k++) begin
                pipe_reg[k] <= pipe_reg[k-1];
            end
            a_reg <= pipe_reg[NS];
            o_reg <= a_reg;
        end
    end

    // quotients fit DW bits, so the top numerator bits start as the remainder
    always_ff @(posedge aclk) begin
        if (en) begin
            rrem_reg[0] <= DW'(nr[NW-1:DW]);
            rlow_reg[0] <= nr[DW-1:0];
            rq_reg[0]   <= '0;
            crem_reg[0] <= DW'(nc[NW-1:DW]);
            clow_reg[0] <= nc[DW-1:0];
            cq_reg[0]   <= '0;
            for (int k = 0; k < NS; k++) begin
                rrem_reg[k+1] <= rge[k] ? DW'(rext[k] - {1'b0, geom.th}) : rext[k][DW-1:0];
                rlow_reg[k+1] <= rlow_reg[k] << 1;
                rq_reg[k+1]   <= {rq_reg[k][DW-2:0], rge[k]};
                crem_reg[k+1] <= cge[k] ? DW'(cext[k] - {1'b0, geom.tw}) : cext[k][DW-1:0];
                clow_reg[k+1] <= clow_reg[k] << 1;
                cq_reg[k+1]   <= {cq_reg[k][DW-2:0], cge[k]};
            end
            addr_reg <= (pipe_reg[NS].kind == lnsc_pkg::KIND_WRITE) ?
                        AW'(pipe_reg[NS].idx) : AW'(lin);
        end
    end

    always_ff @(posedge aclk) begin
        if (en && a_reg.vld) begin
            if (a_reg.kind == lnsc_pkg::KIND_WRITE) begin
                mem[addr_reg] <= a_reg.value;
            end
            rd_reg <= mem[addr_reg];
        end
    end

    assign m_valid  = o_reg.vld;
    assign m_status = o_reg.status;

    always_comb begin
        unique case (o_reg.kind)
            lnsc_pkg::KIND_READ: m_rgba = rd_reg;
            lnsc_pkg::KIND_BG:   m_rgba = lnsc_pkg::BG_PIXEL;
            default:             m_rgba = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== test/tb_letterbox_nearest_scaler_core.sv =====
// Self-checking testbench for letterbox_nearest_scaler_core: register setups, pixel
// writes and canvas reads, checked in order against a built-in letterbox predictor.
// Depends on lnsc_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_letterbox_nearest_scaler_core;
    import lnsc_pkg::*;

    localparam int FRAME_PIXELS = 65536;
    localparam int MAX_DIM      = 4096;
    localparam int ITEM_GOAL    = 1150;
    localparam int CYCLE_LIMIT  = 600000;

    typedef struct {
        bit                 cmd;
        logic [IDX_W-1:0]   idx;
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pix_item_t;

    typedef struct {
        logic [PIX_W-1:0] rgba;
        logic [ST_W-1:0]  status;
    } pix_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_cmd = 1'b0;
    logic [IDX_W-1:0] s_pixel_index = '0;
    logic [PIX_W-1:0] s_pixel_value = '0;
    logic [COORD_W-1:0] s_canvas_x = '0;
    logic [COORD_W-1:0] s_canvas_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [PIX_W-1:0] m_rgba;
    logic [ST_W-1:0] m_status;

    letterbox_nearest_scaler_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_pixel_index(s_pixel_index), .s_pixel_value(s_pixel_value),
        .s_canvas_x(s_canvas_x), .s_canvas_y(s_canvas_y),
        .m_valid(m_valid), .m_ready(m_ready), .m_rgba(m_rgba), .m_status(m_status)
    );

    always #5 aclk = ~aclk;

    // predictor state: register copies and frame store
    logic [DIM_W-1:0] canv_cols = DIM_W'(1), canv_rows = DIM_W'(1);
    logic [DIM_W-1:0] frame_w = DIM_W'(1), frame_h = DIM_W'(1);
    logic [PIX_W-1:0] pix_mem [FRAME_PIXELS];
    bit               planned [FRAME_PIXELS];

    pix_item_t   work_q[$];
    pix_result_t pixel_q[$];
    pix_item_t   cur_item;
    bit          s_fire = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 0;
    bit          calm = 0;
    int          n_accepted = 0, n_checked = 0, n_errors = 0, n_generated = 0;
    int          n_reads = 0, n_setups = 0, cycles = 0;

    function automatic bit canvas_valid();
        return canv_cols != 0 && canv_rows != 0 &&
               canv_cols <= MAX_DIM && canv_rows <= MAX_DIM;
    endfunction

    function automatic bit frame_valid();
        return frame_w != 0 && frame_h != 0 &&
               longint'(frame_w) * longint'(frame_h) <= FRAME_PIXELS;
    endfunction

    // fits the letterbox rectangle; in_box=0 means background
    function automatic void map_to_source(input int unsigned x, input int unsigned y,
                                          output bit in_box, output longint unsigned src);
        longint unsigned fw, fh, cw, ch, tw, th, fwide, cwide, ox, oy, sr, sc;
        fw = frame_w; fh = frame_h; cw = canv_cols; ch = canv_rows;
        tw = cw; th = ch;
        fwide = fw * ch;
        cwide = cw * fh;
        in_box = 0;
        src = 0;
        if (x >= cw || y >= ch) return;
        if (fwide >= cwide) begin
            th = cwide / fw;
            if (th < 1) th = 1;
        end else begin
            tw = fwide / fh;
            if (tw < 1) tw = 1;
        end
        ox = (cw - tw) / 2;
        oy = (ch - th) / 2;
        if (x < ox || x >= ox + tw || y < oy || y >= oy + th) return;
        sr = (y - oy) * fh / th;
        sc = (x - ox) * fw / tw;
        src = sr * fw + sc;
        in_box = 1;
    endfunction

    function automatic pix_result_t scale_predict(input pix_item_t it);
        pix_result_t r;
        bit in_box;
        longint unsigned src;
        r.rgba = '0;
        r.status = ST_OK;
        if (!it.cmd) begin
            if (!frame_valid()) r.status = ST_BAD_FRAME;
            else if (longint'(it.idx) >= longint'(frame_w) * longint'(frame_h))
                r.status = ST_BAD_INDEX;
            else pix_mem[it.idx] = it.value;
        end else if (!canvas_valid()) begin
            r.status = ST_BAD_CANVAS;
        end else if (!frame_valid()) begin
            r.status = ST_BAD_FRAME;
        end else begin
            map_to_source(it.x, it.y, in_box, src);
            if (!in_box) r.rgba = BG_PIXEL;
            else if (src < FRAME_PIXELS) r.rgba = pix_mem[src];
        end
        return r;
    endfunction

    task automatic push_write(input int unsigned idx, input logic [31:0] val);
        pix_item_t it;
        it.cmd = 0; it.idx = IDX_W'(idx); it.value = val;
        it.x = COORD_W'($urandom); it.y = COORD_W'($urandom);
        if (frame_valid() && longint'(idx) < longint'(frame_w) * longint'(frame_h))
            planned[idx] = 1;
        work_q.push_back(it);
        n_generated++;
    endtask

    // a read that lands on an unwritten pixel gets that pixel written first
    task automatic push_read(input int unsigned x, input int unsigned y);
        pix_item_t it;
        bit in_box;
        longint unsigned src;
        it.cmd = 1; it.idx = IDX_W'($urandom); it.value = $urandom;
        it.x = COORD_W'(x); it.y = COORD_W'(y);
        if (canvas_valid() && frame_valid()) begin
            map_to_source(it.x, it.y, in_box, src);
            if (in_box && src < FRAME_PIXELS && !planned[src])
                push_write(32'(src), $urandom);
        end
        work_q.push_back(it);
        n_generated++;
    endtask

    task automatic push_random(input int count);
        int unsigned lim;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                lim = frame_w * frame_h;
                if ($urandom_range(0, 9) == 0 || lim == 0) push_write($urandom_range(0, 65535), $urandom);
                else push_write($urandom_range(0, (lim > 65536 ? 65536 : lim) - 1), $urandom);
            end else if ($urandom_range(0, 9) == 0) begin
                push_read($urandom_range(0, 4095), $urandom_range(0, 4095));
            end else begin
                push_read($urandom_range(0, canv_cols > 4095 ? 4095 : canv_cols + 1),
                          $urandom_range(0, canv_rows > 4095 ? 4095 : canv_rows + 1));
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        case (idx)
            REG_CANVAS_W: canv_cols = data[DIM_W-1:0];
            REG_CANVAS_H: canv_rows = data[DIM_W-1:0];
            REG_FRAME_W:  frame_w   = data[DIM_W-1:0];
            REG_FRAME_H:  frame_h   = data[DIM_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // junk in the upper bits checks that only 13 bits are kept
    task automatic set_geometry(input int cw, input int ch, input int fw, input int fh);
        write_reg(REG_CANVAS_W, cw | ($urandom << DIM_W));
        write_reg(REG_CANVAS_H, ch | ($urandom << DIM_W));
        write_reg(REG_FRAME_W, fw | ($urandom << DIM_W));
        write_reg(REG_FRAME_H, fh | ($urandom << DIM_W));
        for (int i = 0; i < FRAME_PIXELS; i++) planned[i] = 0;
        n_setups++;
    endtask

    task automatic drain();
        while (work_q.size() != 0 || s_valid || pixel_q.size() != 0) @(posedge aclk);
        repeat (25) @(posedge aclk);
    endtask

    // input side
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            pixel_q.push_back(scale_predict(cur_item));
            n_accepted++;
            s_fire = 1;
        end
    end

    always @(negedge aclk) begin
        if (!s_valid || s_fire) begin
            s_fire = 0;
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (aresetn && work_q.size() != 0) begin
                cur_item = work_q.pop_front();
                s_cmd         <= cur_item.cmd;
                s_pixel_index <= cur_item.idx;
                s_pixel_value <= cur_item.value;
                s_canvas_x    <= cur_item.x;
                s_canvas_y    <= cur_item.y;
                s_valid       <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) gap_left = $urandom_range(1, 10);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off, started while plenty of items wait to be sent
    always @(posedge aclk) begin
        if (!hold_done && !calm && n_accepted >= 300 && work_q.size() >= 40) begin
            hold_done = 1;
            hold_left = 200;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // output side: random stalls, plus the long hold-off above
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 10);
        end
    end

    always @(posedge aclk) begin
        pix_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected result rgba=%h status=%0d", $time, m_rgba, m_status);
                n_errors++;
            end else begin
                want = pixel_q.pop_front();
                if (m_rgba !== want.rgba) begin
                    $display("%0t: rgba mismatch expected %h actual %h", $time, want.rgba, m_rgba);
                    n_errors++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d",
                             $time, want.status, m_status);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, pixel_q.size());
            $display("** letterbox_nearest_scaler_core: FAILED **");
            $finish;
        end
    end

    initial begin
        int cw, ch, fw, fh;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset geometry 1x1
        push_write(0, 32'hFFFF_FFFF);
        push_read(0, 0);
        push_read(4095, 4095);
        push_write(65535, 32'h0);
        push_write(1, 32'h1234_5678);
        push_read(1, 0);
        drain();

        // bad canvas; out-of-list register indexes are ignored
        set_geometry(0, 5, 4, 4);
        write_reg(8'd4, 32'h0000_0007);
        write_reg(8'd255, 32'hFFFF_FFFF);
        push_read(2, 2);
        push_write(3, 32'h0);
        push_write(16, 32'hA5A5_A5A5);
        drain();

        // canvas too wide and zero frame width: canvas error wins on reads
        set_geometry(8191, 8, 0, 4);
        push_read(0, 0);
        push_write(0, 32'h1);
        drain();

        // frame bigger than the store
        set_geometry(8, 8, 300, 300);
        push_read(3, 3);
        push_write(5, 32'h2);
        drain();

        // largest canvas, frame filling the whole store
        set_geometry(4096, 4096, 4096, 16);
        push_write(65535, 32'hFFFF_FFFF);
        push_read(4095, 4095);
        push_read(0, 0);
        push_read(0, 2048);
        push_read(4095, 2055);
        push_random(60);
        drain();

        // minimum target side clamps to one on each axis
        set_geometry(1, 4096, 4096, 1);
        push_read(0, 2047);
        push_read(0, 2048);
        push_read(0, 4095);
        push_random(30);
        drain();
        set_geometry(4096, 1, 1, 4096);
        push_read(2047, 0);
        push_read(2048, 0);
        push_random(30);
        drain();

        while (n_generated < ITEM_GOAL) begin
            if (n_generated > ITEM_GOAL - 160) calm = 1;
            if ($urandom_range(0, 19) == 0) begin
                cw = $urandom_range(0, 8191); ch = $urandom_range(0, 64);
                fw = $urandom_range(0, 40);   fh = $urandom_range(0, 40);
            end else if ($urandom_range(0, 7) == 0) begin
                cw = $urandom_range(1, 4096); ch = $urandom_range(1, 4096);
                fw = $urandom_range(1, 64);   fh = $urandom_range(1, 64);
            end else begin
                cw = $urandom_range(1, 48); ch = $urandom_range(1, 48);
                fw = $urandom_range(1, 24); fh = $urandom_range(1, 24);
            end
            set_geometry(cw, ch, fw, fh);
            push_random(calm ? 160 : $urandom_range(60, 120));
            drain();
        end

        $display("Checked %0d results from %0d items over %0d geometry setups,",
                 n_checked, n_accepted, n_setups);
        $display("including bad sizes, bad indexes, borders and a long output stall.");
        if (n_errors == 0 && pixel_q.size() == 0) begin
            $display("** letterbox_nearest_scaler_core: PASSED **");
        end else begin
            $display("** letterbox_nearest_scaler_core: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/lnsc_pkg.sv
rtl/core/lnsc_front.sv
rtl/core/lnsc_fifo.sv
rtl/core/lnsc_back.sv
rtl/core/letterbox_nearest_scaler_core.sv
test/tb_letterbox_nearest_scaler_core.sv
